>>> sv/kro_pkg.sv
// ============================================================================
// kro_pkg - shared definitions for the key replacement order list
// Field widths, operation and policy codes, register indexes and the result
// word of the shared compare unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kro_pkg;

    localparam int KEY_W  = 16;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 5;

    // operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // policy codes; the spare code behaves as circular
    localparam logic [1:0] POL_FIFO    = 2'd0;
    localparam logic [1:0] POL_LRU     = 2'd1;
    localparam logic [1:0] POL_LARGEST = 2'd2;

    // register index (taken from paddr[2])
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic eq;   // keys match
        logic gt;   // incoming size strictly larger than stored size
    } t_cmp;

endpackage

`default_nettype wire

>>> sv/kro_mem.sv
// ============================================================================
// kro_mem - slot store
// Single write port, single read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kro_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wa,
    input  wire logic [DW-1:0]            i_wd,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_ra,
    output logic      [DW-1:0]            o_rd
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end

endmodule

`default_nettype wire

>>> sv/kro_cmp.sv
// ============================================================================
// kro_cmp - shared compare unit
// Key equality and size ordering against one slot read from the store.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kro_cmp #(
    parameter int KW = 16
) (
    input  wire logic [KW-1:0]             i_key_a,
    input  wire logic [KW-1:0]             i_key_b,
    input  wire logic [kro_pkg::SIZE_W-1:0] i_size_a,
    input  wire logic [kro_pkg::SIZE_W-1:0] i_size_b,
    output kro_pkg::t_cmp                   o_res
);

    always_comb begin
        o_res.eq = (i_key_a == i_key_b);
        o_res.gt = (i_size_a > i_size_b);
    end

endmodule

`default_nettype wire

>>> sv/key_replacement_order_list_core.sv
// ============================================================================
// key_replacement_order_list_core - replacement order list for a key store
// Ordered list of (key, size) pairs whose head is the next eviction victim,
// kept in a slot store with one read and one write port and updated by a
// small sequencer.
// ============================================================================
// A command is taken when start is high and busy is low; busy then stays high
// until the result word has been formed, and the result is shown for exactly
// one cycle with o_result_valid high. The receiver cannot stall, so sample the
// result on that cycle. A command reads each held slot once, moves the slots
// behind a removed entry and those behind the insertion point one place each,
// writes the new entry when it places one (not on a remove, a dropped add or
// a circular add of a key already held) and reads back the head; each slot
// move is a registered read followed by a write on the store, which has
// one read and one write port and registered read data.
// The policy register sits at byte address 0 and may only be written while
// busy is low and no result is pending.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module key_replacement_order_list_core #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // command
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_operation,
    input  wire logic [kro_pkg::KEY_W-1:0]    i_key_id,
    input  wire logic [kro_pkg::SIZE_W-1:0]   i_entry_size,
    // result
    output logic                              o_result_valid,
    output logic      [kro_pkg::KEY_W-1:0]    o_victim_key,
    output logic                              o_has_victim,
    output logic      [kro_pkg::CNT_W-1:0]    o_entry_count,
    output logic                              o_add_dropped
);

    // stored key width: keys are masked to KEY_BITS, never wider than the port
    localparam int KW = (KEY_BITS < kro_pkg::KEY_W) ? KEY_BITS : kro_pkg::KEY_W;
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = KW + kro_pkg::SIZE_W;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_SCAN_RD = 11'b00000000010,
        S_SCAN_CK = 11'b00000000100,
        S_DECIDE  = 11'b00000001000,
        S_DEL_RD  = 11'b00000010000,
        S_DEL_WR  = 11'b00000100000,
        S_INS_RD  = 11'b00001000000,
        S_INS_WR  = 11'b00010000000,
        S_PUT     = 11'b00100000000,
        S_HEAD_RD = 11'b01000000000,
        S_REPORT  = 11'b10000000000
    } t_state;

    // control state
    t_state                      r_state,  n_state;
    logic [1:0]                  r_policy;
    logic [CW-1:0]               r_cnt,    n_cnt;
    logic                        r_res_valid, n_res_valid;

    // per-command working registers
    logic                        r_op,     n_op;
    logic [KW-1:0]               r_key,    n_key;
    logic [kro_pkg::SIZE_W-1:0]  r_size,   n_size;
    logic [CW-1:0]               r_j,      n_j;
    logic [CW-1:0]               r_p,      n_p;
    logic [CW-1:0]               r_q,      n_q;
    logic                        r_found,  n_found;
    logic                        r_gtf,    n_gtf;
    logic                        r_do_ins, n_do_ins;
    logic                        r_dropped, n_dropped;

    // result word
    logic [kro_pkg::KEY_W-1:0]   r_victim, n_victim;
    logic                        r_has,    n_has;
    logic [kro_pkg::CNT_W-1:0]   r_count,  n_count;
    logic                        r_drop_out, n_drop_out;

    // store and compare unit
    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_wa, mem_ra;
    logic [DW-1:0]               mem_wd, mem_rd;
    logic [KW-1:0]               rd_key;
    logic [kro_pkg::SIZE_W-1:0]  rd_size;
    kro_pkg::t_cmp               cmp;

    logic                        cfg_wr;

    assign rd_key  = mem_rd[DW-1:kro_pkg::SIZE_W];
    assign rd_size = mem_rd[kro_pkg::SIZE_W-1:0];

    kro_mem #(
        .DEPTH (ENTRIES),
        .DW    (DW)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    kro_cmp #(
        .KW (KW)
    ) u_cmp (
        .i_key_a  (r_key),
        .i_key_b  (rd_key),
        .i_size_a (r_size),
        .i_size_b (rd_size),
        .o_res    (cmp)
    );

    // ------------------------------------------------------------------------
    // Configuration port: no wait states, one register
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == kro_pkg::REG_POLICY);
    assign prdata = (paddr[2] == kro_pkg::REG_POLICY) ? 32'(r_policy) : '0;

    // ------------------------------------------------------------------------
    // Sequencer
    // Scan every held slot once, remembering the match and the first slot of
    // strictly smaller size; then close the gap of a deleted entry, open a gap
    // at the insertion point, drop the new entry in and read back the head.
    // ------------------------------------------------------------------------
    always_comb begin
        logic          l_circ;
        logic          l_do_del;
        logic          l_skip;
        logic          l_full;
        logic [CW-1:0] l_pc;
        logic [CW-1:0] l_jn;
        logic [CW-1:0] l_jp;

        l_circ   = !((r_policy == kro_pkg::POL_LRU) || (r_policy == kro_pkg::POL_LARGEST));
        // delete on remove, or on refresh under the reordering policies
        l_do_del = r_found && ((r_op == kro_pkg::OP_REMOVE) || !l_circ);
        l_pc     = r_cnt - CW'(l_do_del);
        // no insertion on remove, nor on an add of a present key when circular
        l_skip   = (r_op == kro_pkg::OP_REMOVE) || (l_circ && r_found);
        l_full   = (l_pc == CW'(ENTRIES));
        l_jn     = r_j + 1'b1;
        l_jp     = r_j - 1'b1;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_op        = r_op;
        n_key       = r_key;
        n_size      = r_size;
        n_j         = r_j;
        n_p         = r_p;
        n_q         = r_q;
        n_found     = r_found;
        n_gtf       = r_gtf;
        n_do_ins    = r_do_ins;
        n_dropped   = r_dropped;
        n_victim    = r_victim;
        n_has       = r_has;
        n_count     = r_count;
        n_drop_out  = r_drop_out;

        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = mem_rd;
        mem_re = 1'b0;
        mem_ra = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_key   = i_key_id[KW-1:0];
                    n_size  = i_entry_size;
                    n_j     = '0;
                    n_p     = '0;
                    n_q     = '0;
                    n_found = 1'b0;
                    n_gtf   = 1'b0;
                    n_state = (r_cnt == '0) ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_j[AW-1:0];
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (cmp.eq && !r_found) begin
                    n_found = 1'b1;
                    n_p     = r_j;
                end
                // insertion point counted in the list with the match taken out
                if (!cmp.eq && cmp.gt && !r_gtf) begin
                    n_gtf = 1'b1;
                    n_q   = r_j - CW'(r_found);
                end
                if (r_j == r_cnt - 1'b1) begin
                    n_state = S_DECIDE;
                end else begin
                    n_j     = l_jn;
                    n_state = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                n_cnt     = l_pc;
                n_dropped = !l_skip && l_full;
                n_do_ins  = !l_skip && !l_full;
                if (!((r_policy == kro_pkg::POL_LARGEST) && r_gtf)) begin
                    n_q = l_pc;
                end
                if (l_do_del && (r_p < l_pc)) begin
                    n_j     = r_p;
                    n_state = S_DEL_RD;
                end else if (!l_skip && !l_full) begin
                    n_j     = l_pc;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_DEL_RD: begin
                mem_re  = 1'b1;
                mem_ra  = l_jn[AW-1:0];
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                // pull the following slot down one place
                mem_we = 1'b1;
                mem_wa = r_j[AW-1:0];
                mem_wd = mem_rd;
                n_j    = l_jn;
                if (l_jn < r_cnt) begin
                    n_state = S_DEL_RD;
                end else if (r_do_ins) begin
                    n_j     = r_cnt;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_INS_RD: begin
                if (r_j > r_q) begin
                    mem_re  = 1'b1;
                    mem_ra  = l_jp[AW-1:0];
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_INS_WR: begin
                // push the preceding slot up one place
                mem_we  = 1'b1;
                mem_wa  = r_j[AW-1:0];
                mem_wd  = mem_rd;
                n_j     = l_jp;
                n_state = S_INS_RD;
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_q[AW-1:0];
                mem_wd  = {r_key, r_size};
                n_cnt   = r_cnt + 1'b1;
                n_state = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                mem_re  = 1'b1;
                mem_ra  = '0;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_res_valid = 1'b1;
                n_has       = (r_cnt != '0);
                n_victim    = (r_cnt != '0) ? kro_pkg::KEY_W'(rd_key) : '0;
                n_count     = kro_pkg::CNT_W'(r_cnt);
                n_drop_out  = r_dropped;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= kro_pkg::POL_FIFO;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
            if (cfg_wr) begin
                r_policy <= pwdata[1:0];
            end
        end
    end

    // working and result registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_size     <= n_size;
        r_j        <= n_j;
        r_p        <= n_p;
        r_q        <= n_q;
        r_found    <= n_found;
        r_gtf      <= n_gtf;
        r_do_ins   <= n_do_ins;
        r_dropped  <= n_dropped;
        r_victim   <= n_victim;
        r_has      <= n_has;
        r_count    <= n_count;
        r_drop_out <= n_drop_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_victim_key   = r_victim;
    assign o_has_victim   = r_has;
    assign o_entry_count  = r_count;
    assign o_add_dropped  = r_drop_out;

endmodule

`default_nettype wire

>>> sv/kro_chk.sv
// ============================================================================
// kro_chk - port-level checks for the replacement order list
// Sequencing of busy against the result strobe and consistency of the word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kro_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_result_valid,
    input wire logic [kro_pkg::KEY_W-1:0]  o_victim_key,
    input wire logic                       o_has_victim,
    input wire logic [kro_pkg::CNT_W-1:0]  o_entry_count,
    input wire logic                       o_add_dropped
);

    // an accepted command holds the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted command");

    // finishing a command always hands out its word
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result word");

    // one word per command, never two back to back
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // an empty list reports no victim key and no count; a drop needs a non-empty list
    a_word_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            ((o_has_victim || ((o_victim_key == '0) && (o_entry_count == '0)))
             && (!o_add_dropped || o_has_victim)))
        else $error("inconsistent result word");

endmodule

bind key_replacement_order_list_core kro_chk u_kro_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_victim_key   (o_victim_key),
    .o_has_victim   (o_has_victim),
    .o_entry_count  (o_entry_count),
    .o_add_dropped  (o_add_dropped)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// ============================================================================
// testbench - key replacement order list, self-checking bench
// Drives add and remove commands through the start/busy handshake under every
// replacement policy, predicts each result word from a shadow list held in a
// small scoreboard, and compares the head key, non-empty flag, entry count and
// drop flag of every strobed result against that prediction.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int          LIST_DEPTH = 16;
    // unused policy code; the block treats it as circular
    localparam logic [1:0]  POL_SPARE  = 2'd3;
    localparam int          PHASE_LEN  = 140;
    localparam int          SETTLE_CYC = 120;

    typedef struct packed {
        logic [kro_pkg::KEY_W-1:0] victim_key;
        logic                      has_victim;
        logic [kro_pkg::CNT_W-1:0] entry_count;
        logic                      add_dropped;
    } victim_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the eviction order plus the queue of result
    // words still owed by the block.
    // ------------------------------------------------------------------------
    class victim_tracker;
        logic [kro_pkg::KEY_W-1:0]  list_keys[$];
        logic [kro_pkg::SIZE_W-1:0] list_sizes[$];
        logic [1:0]                 policy = kro_pkg::POL_FIFO;
        victim_word_t               pending_victims[$];
        int unsigned                errors = 0;

        function int find_key(logic [kro_pkg::KEY_W-1:0] key);
            foreach (list_keys[i])
                if (list_keys[i] == key)
                    return i;
            return -1;
        endfunction

        // Apply one accepted command to the shadow list and queue its result.
        function void note_command(logic op, logic [kro_pkg::KEY_W-1:0] key,
                                   logic [kro_pkg::SIZE_W-1:0] size);
            int           pos;
            int           slot;
            bit           reorder;
            bit           dropped;
            victim_word_t w;
            pos     = find_key(key);
            reorder = (policy == kro_pkg::POL_LRU) || (policy == kro_pkg::POL_LARGEST);
            dropped = 1'b0;
            if (op == kro_pkg::OP_REMOVE) begin
                if (pos >= 0) begin
                    list_keys.delete(pos);
                    list_sizes.delete(pos);
                end
            end else if (pos < 0 || reorder) begin
                if (pos >= 0) begin
                    list_keys.delete(pos);
                    list_sizes.delete(pos);
                end
                if (list_keys.size() >= LIST_DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    slot = list_keys.size();
                    if (policy == kro_pkg::POL_LARGEST) begin
                        for (int i = 0; i < list_sizes.size(); i++) begin
                            if (size > list_sizes[i]) begin
                                slot = i;
                                break;
                            end
                        end
                    end
                    list_keys.insert(slot, key);
                    list_sizes.insert(slot, size);
                end
            end
            w.victim_key  = (list_keys.size() > 0) ? list_keys[0] : '0;
            w.has_victim  = (list_keys.size() > 0);
            w.entry_count = kro_pkg::CNT_W'(list_keys.size());
            w.add_dropped = dropped;
            pending_victims.push_back(w);
        endfunction

        function void check_word(victim_word_t got);
            victim_word_t exp_w;
            if (pending_victims.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending_victims.pop_front();
            if (got.victim_key !== exp_w.victim_key) begin
                $display("%0t: victim_key expected %h got %h",
                         $time, exp_w.victim_key, got.victim_key);
                errors++;
            end
            if (got.has_victim !== exp_w.has_victim) begin
                $display("%0t: has_victim expected %b got %b",
                         $time, exp_w.has_victim, got.has_victim);
                errors++;
            end
            if (got.entry_count !== exp_w.entry_count) begin
                $display("%0t: entry_count expected %0d got %0d",
                         $time, exp_w.entry_count, got.entry_count);
                errors++;
            end
            if (got.add_dropped !== exp_w.add_dropped) begin
                $display("%0t: add_dropped expected %b got %b",
                         $time, exp_w.add_dropped, got.add_dropped);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; every input holds a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [2:0]                 paddr        = '0;
    logic [31:0]                pwdata       = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       start        = 1'b0;
    logic                       busy;
    logic                       i_operation  = kro_pkg::OP_ADD;
    logic [kro_pkg::KEY_W-1:0]  i_key_id     = '0;
    logic [kro_pkg::SIZE_W-1:0] i_entry_size = '0;
    logic                       o_result_valid;
    logic [kro_pkg::KEY_W-1:0]  o_victim_key;
    logic                       o_has_victim;
    logic [kro_pkg::CNT_W-1:0]  o_entry_count;
    logic                       o_add_dropped;

    victim_tracker sb = new;

    always #5 i_clk = ~i_clk;

    key_replacement_order_list_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_key_id       (i_key_id),
        .i_entry_size   (i_entry_size),
        .o_result_valid (o_result_valid),
        .o_victim_key   (o_victim_key),
        .o_has_victim   (o_has_victim),
        .o_entry_count  (o_entry_count),
        .o_add_dropped  (o_add_dropped)
    );

    // Result monitor: the strobe lasts one cycle and cannot be held off, so
    // take the word at the edge that closes that cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_word('{victim_key:  o_victim_key,
                            has_victim:  o_has_victim,
                            entry_count: o_entry_count,
                            add_dropped: o_add_dropped});
    end

    // Hard stop in case the block hangs or never answers.
    initial begin
        #8ms;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drive tasks. Each is entered and left on a rising edge; start is left
    // high after acceptance so back-to-back words need no second assignment.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [kro_pkg::KEY_W-1:0] key,
                             input logic [kro_pkg::SIZE_W-1:0] size);
        start        <= 1'b1;
        i_operation  <= op;
        i_key_id     <= key;
        i_entry_size <= size;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, key, size);
    endtask

    // Drop start for a number of cycles, scrambling the idle payload.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            start        <= 1'b0;
            i_operation  <= 1'($urandom_range(0, 1));
            i_key_id     <= kro_pkg::KEY_W'($urandom);
            i_entry_size <= kro_pkg::SIZE_W'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold off until every owed result has arrived and the block is idle.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending_victims.size() != 0 || busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access until pready; only when idle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == kro_pkg::REG_POLICY)
            sb.policy = data[1:0];
    endtask

    task automatic set_policy(input logic [1:0] pol);
        write_reg({kro_pkg::REG_POLICY, 2'b00},
                  {30'($urandom_range(0, 32'h3fff_ffff)), pol});
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0]                 phase_policy[6];
        logic [kro_pkg::KEY_W-1:0]  pool_base;
        int                         pool_size;
        int                         add_pct;
        bit                         burst;
        logic                       op;
        logic [kro_pkg::KEY_W-1:0]  key;
        logic [kro_pkg::SIZE_W-1:0] size;
        int                         r;

        phase_policy = '{kro_pkg::POL_FIFO, kro_pkg::POL_LRU, kro_pkg::POL_LARGEST,
                         POL_SPARE, kro_pkg::POL_LARGEST, kro_pkg::POL_LRU};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Circular policy straight out of reset: extreme keys and sizes, a
        // repeated add left in place, removes of missing, head and last keys,
        // and a remove on an empty list.
        send_word(kro_pkg::OP_ADD,    16'h0000, 16'h0000);
        send_word(kro_pkg::OP_ADD,    16'hffff, 16'hffff);
        send_word(kro_pkg::OP_ADD,    16'h0000, 16'h1234);
        send_word(kro_pkg::OP_REMOVE, 16'h5555, 16'h0000);
        idle_sender(pick_gap(1'b0));
        send_word(kro_pkg::OP_REMOVE, 16'h0000, 16'hffff);
        send_word(kro_pkg::OP_REMOVE, 16'hffff, 16'h0000);
        send_word(kro_pkg::OP_REMOVE, 16'hffff, 16'h0000);

        // LRU: refresh moves a key to the tail.
        set_policy(kro_pkg::POL_LRU);
        send_word(kro_pkg::OP_ADD,    16'h0001, 16'h0001);
        send_word(kro_pkg::OP_ADD,    16'h0002, 16'h0002);
        send_word(kro_pkg::OP_ADD,    16'h0003, 16'h0003);
        send_word(kro_pkg::OP_ADD,    16'h0001, 16'h0004);
        send_word(kro_pkg::OP_REMOVE, 16'h0002, 16'h0000);

        // Largest first: equal sizes queue behind, largest goes to the head,
        // a refresh with a new size repositions the key.
        set_policy(kro_pkg::POL_LARGEST);
        send_word(kro_pkg::OP_ADD,    16'h0010, 16'd5);
        send_word(kro_pkg::OP_ADD,    16'h0011, 16'd10);
        send_word(kro_pkg::OP_ADD,    16'h0012, 16'd10);
        send_word(kro_pkg::OP_ADD,    16'h0013, 16'd0);
        send_word(kro_pkg::OP_ADD,    16'h0014, 16'hffff);
        send_word(kro_pkg::OP_ADD,    16'h0013, 16'h8000);

        // Spare code runs as circular; a write to an unmapped address is void.
        set_policy(POL_SPARE);
        send_word(kro_pkg::OP_ADD,    16'h0020, 16'h0020);
        send_word(kro_pkg::OP_ADD,    16'h0020, 16'h0040);
        write_reg({~kro_pkg::REG_POLICY, 2'b00}, 32'h0000_0001);
        send_word(kro_pkg::OP_ADD,    16'h0010, 16'h0000);

        // Random phases: a narrow key pool keeps hits, refreshes and full-list
        // drops frequent; a few wide keys and sizes sweep every bit.
        foreach (phase_policy[p]) begin
            set_policy(phase_policy[p]);
            pool_base = kro_pkg::KEY_W'($urandom);
            r = $urandom_range(0, 3);
            pool_size = (r == 0) ? 6 : (r == 1) ? 14 : (r == 2) ? 24 : 64;
            add_pct   = (p % 2 == 0) ? 75 : 60;
            burst     = 1'b0;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 30 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                op = ($urandom_range(0, 99) < add_pct) ? kro_pkg::OP_ADD
                                                       : kro_pkg::OP_REMOVE;
                if ($urandom_range(0, 9) == 0)
                    key = kro_pkg::KEY_W'($urandom);
                else
                    key = pool_base +
                          kro_pkg::KEY_W'($urandom_range(0, pool_size - 1));
                r = $urandom_range(0, 9);
                if (r < 4)
                    size = kro_pkg::SIZE_W'($urandom_range(0, 7));
                else if (r == 4)
                    size = (r[0]) ? '1 : ($urandom_range(0, 1) ? '1 : '0);
                else
                    size = kro_pkg::SIZE_W'($urandom);
                send_word(op, key, size);
                // Now and then let the pipeline run dry before the next word.
                if (n == 70 || $urandom_range(0, 99) == 0)
                    wait_drained();
                else
                    idle_sender(pick_gap(burst));
            end
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_victims.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
